// ===== design/sdp_pkg.sv =====
// ----------------------------------------------------------------------------
// Step/direction pulse generator package
// Shared widths, codes, configuration and result types.
// ----------------------------------------------------------------------------
package sdp_pkg;

    localparam int STEP_BITS  = 20;
    localparam int POS_BITS   = 32;
    localparam int DLY_BITS   = 10;
    localparam int REQ_BITS   = 16;
    localparam int CNT_BITS   = 20;
    localparam int FUNC_BITS  = 2;
    localparam int EV_BITS    = 3;
    localparam int CIDX_BITS  = 2;
    localparam int IN_BYTES   = 5;
    localparam int OUT_BYTES  = 6;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    localparam logic [FUNC_BITS-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_STOP  = 2'd2;

    localparam logic [EV_BITS-1:0] EV_PIN    = 3'd0;
    localparam logic [EV_BITS-1:0] EV_ACK    = 3'd1;
    localparam logic [EV_BITS-1:0] EV_BAD    = 3'd2;
    localparam logic [EV_BITS-1:0] EV_CANCEL = 3'd3;
    localparam logic [EV_BITS-1:0] EV_DONE   = 3'd4;
    localparam logic [EV_BITS-1:0] EV_STOP   = 3'd5;

    localparam logic [CIDX_BITS-1:0] CFG_DIR_SETUP = 2'd0;
    localparam logic [CIDX_BITS-1:0] CFG_MIN_HALF  = 2'd1;
    localparam logic [CIDX_BITS-1:0] CFG_MAX_HALF  = 2'd2;

    localparam logic [DLY_BITS-1:0] RST_DIR_SETUP = 10'd100;
    localparam logic [DLY_BITS-1:0] RST_MIN_HALF  = 10'd200;
    localparam logic [DLY_BITS-1:0] RST_MAX_HALF  = 10'd1000;
    localparam logic [DLY_BITS-1:0] RST_HALF      = 10'd200;

    typedef enum logic [1:0] {
        PH_SETUP = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [DLY_BITS-1:0] dir_setup;
        logic [DLY_BITS-1:0] min_half;
        logic [DLY_BITS-1:0] max_half;
    } t_cfg;

    typedef struct packed {
        logic [EV_BITS-1:0]  event_res;
        logic                step_level;
        logic                dir_level;
        logic [31:0]         position;
        logic                moving;
        logic                was_moving;
        logic [DLY_BITS-1:0] applied_delay;
        logic                last;
    } t_result;

endpackage

// ===== design/sdp_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the direction setup time and the half-step delay clamp limits.
// ----------------------------------------------------------------------------
module sdp_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sdp_pkg::CIDX_BITS-1:0] i_cfg_index,
    input  logic [sdp_pkg::DLY_BITS-1:0]  i_cfg_data,
    output sdp_pkg::t_cfg                 o_cfg
);
    import sdp_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dir_setup <= RST_DIR_SETUP;
            r_cfg.min_half  <= RST_MIN_HALF;
            r_cfg.max_half  <= RST_MAX_HALF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DIR_SETUP: r_cfg.dir_setup <= i_cfg_data;
                CFG_MIN_HALF:  r_cfg.min_half  <= i_cfg_data;
                CFG_MAX_HALF:  r_cfg.max_half  <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== design/sdp_core.sv =====
// ----------------------------------------------------------------------------
// Axis core
// Input word register, axis state and the single-pass update that turns one
// word into up to two result words.
// ----------------------------------------------------------------------------
module sdp_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sdp_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sdp_pkg::FUNC_BITS-1:0] i_func,
    input  logic [sdp_pkg::CNT_BITS-1:0]  i_step_count,
    input  logic                          i_turn_cw,
    input  logic [sdp_pkg::REQ_BITS-1:0]  i_half_delay_req,
    input  logic                          i_space,
    output logic [1:0]                    o_push,
    output sdp_pkg::t_result              o_res0,
    output sdp_pkg::t_result              o_res1
);
    import sdp_pkg::*;

    logic                 r_in_valid;
    logic [FUNC_BITS-1:0] r_func;
    logic [STEP_BITS-1:0] r_cnt;
    logic                 r_cw;
    logic [REQ_BITS-1:0]  r_req;

    t_phase               r_phase,  n_phase;
    logic                 r_busy,   n_busy;
    logic [STEP_BITS-1:0] r_steps,  n_steps;
    logic                 r_dir_cw, n_dir_cw;
    logic [DLY_BITS-1:0]  r_half,   n_half;
    logic [DLY_BITS-1:0]  r_el,     n_el;
    logic                 r_first,  n_first;
    logic [POS_BITS-1:0]  r_pos,    n_pos;
    logic                 r_step,   n_step;
    logic                 r_dir,    n_dir;

    logic                 fire;
    logic                 done;
    logic [DLY_BITS-1:0]  el_inc;
    logic [DLY_BITS-1:0]  wait_ticks;
    logic [DLY_BITS-1:0]  clamped;
    logic [STEP_BITS-1:0] steps_dec;
    logic [31:0]          pos_ext;

    assign fire    = r_in_valid && i_space;
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_func <= i_func;
            r_cnt  <= i_step_count[STEP_BITS-1:0];
            r_cw   <= i_turn_cw;
            r_req  <= i_half_delay_req;
        end
    end

    always_comb begin
        if (r_req < REQ_BITS'(i_cfg.min_half)) begin
            clamped = i_cfg.min_half;
        end else if (r_req > REQ_BITS'(i_cfg.max_half)) begin
            clamped = i_cfg.max_half;
        end else begin
            clamped = r_req[DLY_BITS-1:0];
        end
    end

    assign el_inc     = (r_el != '1) ? r_el + DLY_BITS'(1) : r_el;
    assign wait_ticks = r_first ? i_cfg.dir_setup : r_half;
    assign steps_dec  = r_steps - STEP_BITS'(1);

    // Next state of the axis.
    always_comb begin
        n_phase  = r_phase;
        n_busy   = r_busy;
        n_steps  = r_steps;
        n_dir_cw = r_dir_cw;
        n_half   = r_half;
        n_el     = r_el;
        n_first  = r_first;
        n_pos    = r_pos;
        n_step   = r_step;
        n_dir    = r_dir;
        done     = 1'b0;
        case (r_func)
            FUNC_TICK: begin
                if (r_busy) begin
                    case (r_phase)
                        PH_HIGH: begin
                            if (el_inc >= wait_ticks) begin
                                n_step  = 1'b1;
                                n_el    = '0;
                                n_phase = PH_LOW;
                            end else begin
                                n_el = el_inc;
                            end
                        end
                        PH_LOW: begin
                            if (el_inc >= r_half) begin
                                n_step  = 1'b0;
                                n_pos   = r_dir_cw ? r_pos + POS_BITS'(1)
                                                   : r_pos - POS_BITS'(1);
                                n_steps = steps_dec;
                                n_el    = '0;
                                if (steps_dec == '0) begin
                                    n_busy = 1'b0;
                                    done   = 1'b1;
                                end else begin
                                    n_first = 1'b0;
                                    n_phase = PH_HIGH;
                                end
                            end else begin
                                n_el = el_inc;
                            end
                        end
                        default: begin
                            n_dir   = r_dir_cw;
                            n_el    = '0;
                            n_phase = PH_HIGH;
                        end
                    endcase
                end
            end
            FUNC_START: begin
                if (r_cnt != '0) begin
                    n_steps  = r_cnt;
                    n_dir_cw = r_cw;
                    n_half   = clamped;
                    n_phase  = PH_SETUP;
                    n_first  = 1'b1;
                    n_el     = '0;
                    n_busy   = 1'b1;
                end
            end
            FUNC_STOP: begin
                n_busy = 1'b0;
            end
            default: ;
        endcase
    end

    assign pos_ext = 32'(signed'(n_pos));

    // Result words for the current input word.
    always_comb begin
        o_res0               = '0;
        o_res0.step_level    = n_step;
        o_res0.dir_level     = n_dir;
        o_res0.position      = pos_ext;
        o_res0.moving        = n_busy;
        o_res0.last          = 1'b1;
        o_res1               = o_res0;
        o_res1.event_res     = EV_ACK;
        o_res1.applied_delay = clamped;
        o_push               = 2'd0;
        case (r_func)
            FUNC_TICK: begin
                o_res0.event_res = done ? EV_DONE : EV_PIN;
                o_push           = 2'd1;
            end
            FUNC_START: begin
                if (r_cnt == '0) begin
                    o_res0.event_res = EV_BAD;
                    o_push           = 2'd1;
                end else if (r_busy) begin
                    o_res0.event_res = EV_CANCEL;
                    o_res0.last      = 1'b0;
                    o_push           = 2'd2;
                end else begin
                    o_res0 = o_res1;
                    o_push = 2'd1;
                end
            end
            FUNC_STOP: begin
                o_res0.event_res  = EV_STOP;
                o_res0.was_moving = r_busy;
                o_push            = 2'd1;
            end
            default: ;
        endcase
        if (!fire) begin
            o_push = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SETUP;
            r_busy   <= 1'b0;
            r_steps  <= '0;
            r_dir_cw <= 1'b1;
            r_half   <= RST_HALF;
            r_el     <= '0;
            r_first  <= 1'b1;
            r_pos    <= '0;
            r_step   <= 1'b0;
            r_dir    <= 1'b0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_busy   <= n_busy;
            r_steps  <= n_steps;
            r_dir_cw <= n_dir_cw;
            r_half   <= n_half;
            r_el     <= n_el;
            r_first  <= n_first;
            r_pos    <= n_pos;
            r_step   <= n_step;
            r_dir    <= n_dir;
        end
    end

`ifndef SYNTHESIS
    a_step_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_step) |-> $past(r_phase) == PH_HIGH)
        else $error("step output rose outside the high wait");

    a_busy_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> r_steps != '0)
        else $error("move started with zero steps");

    a_push_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push != 2'd0 |-> fire)
        else $error("result pushed without a word being processed");
`endif

endmodule

// ===== design/sdp_outq.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Four-word queue that takes one or two result words per cycle and hands
// them to the output stream in order.
// ----------------------------------------------------------------------------
module sdp_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push,
    input  sdp_pkg::t_result i_res0,
    input  sdp_pkg::t_result i_res1,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output sdp_pkg::t_result o_res
);
    import sdp_pkg::*;

    t_result               r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr, r_rd;
    logic [Q_PTR_BITS:0]   r_count;
    logic                  pop;
    logic [Q_PTR_BITS-1:0] wr_next;

    assign o_valid = (r_count != '0);
    assign o_space = (r_count <= (Q_PTR_BITS+1)'(Q_DEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign o_res   = r_mem[r_rd];
    assign wr_next = r_wr + Q_PTR_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push == 2'd2) begin
            r_mem[wr_next] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + Q_PTR_BITS'(i_push);
            r_rd    <= r_rd + Q_PTR_BITS'(pop);
            r_count <= r_count + (Q_PTR_BITS+1)'(i_push) - (Q_PTR_BITS+1)'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_PTR_BITS+1)'(Q_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push != 2'd0 |-> o_space)
        else $error("result pushed without room");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push == 2'd0 && !pop) |=> $stable(r_count))
        else $error("queue count changed without push or pop");
`endif

endmodule

// ===== design/stepper_step_dir_pulse_generator_top.sv =====
// ----------------------------------------------------------------------------
// Stepper step/direction pulse generator, top level
// One-axis generator driven by one-microsecond tick words, start and stop
// commands; reports pin levels, position and move events as result words.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle while the result queue has
// room, and gives one result word for each tick, stop or start, two for a
// start that cancels a running move, and none for an unused function code. A
// result word passes through the input register, whose state update writes
// the four-word result queue, and then through the queue before it can be
// taken at the output. The queue sets the sustained rate: the input side
// stalls whenever the queue holds three or more words, which takes an output
// stall or a second cancelling start before the queue has drained.
module stepper_step_dir_pulse_generator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // step_count [19:0], turn_cw [20], half_delay_req [36:21], zero fill
    input  logic [8*sdp_pkg::IN_BYTES-1:0]  i_s_tdata,
    // func [1:0]
    input  logic [sdp_pkg::FUNC_BITS-1:0] i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // step_level [0], dir_level [1], position [33:2], moving [34],
    // was_moving [35], applied_delay [45:36], zero fill
    output logic [8*sdp_pkg::OUT_BYTES-1:0] o_m_tdata,
    // event_res [2:0]
    output logic [sdp_pkg::EV_BITS-1:0]   o_m_tuser,
    output logic                          o_m_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sdp_pkg::CIDX_BITS-1:0] i_cfg_index,
    input  logic [sdp_pkg::DLY_BITS-1:0]  i_cfg_data
);
    import sdp_pkg::*;

    t_cfg    cfg;
    t_result res0, res1, res_out;
    logic    space;
    logic [1:0] push;

    sdp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sdp_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_func           (i_s_tuser),
        .i_step_count     (i_s_tdata[CNT_BITS-1:0]),
        .i_turn_cw        (i_s_tdata[CNT_BITS]),
        .i_half_delay_req (i_s_tdata[CNT_BITS+REQ_BITS:CNT_BITS+1]),
        .i_space          (space),
        .o_push           (push),
        .o_res0           (res0),
        .o_res1           (res1)
    );

    sdp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_space (space),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res_out)
    );

    assign o_m_tuser = res_out.event_res;
    assign o_m_tlast = res_out.last;
    assign o_m_tdata = {2'b00, res_out.applied_delay, res_out.was_moving,
                        res_out.moving, res_out.position, res_out.dir_level,
                        res_out.step_level};

endmodule

// ===== tb/stepper_step_dir_pulse_generator_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Step/direction pulse generator testbench
// Drives tick, start and stop words with random gaps and output stalls across
// several register settings. An in-bench axis model predicts every result word
// (pins, position, events), and each returned word is checked field by field.
// ----------------------------------------------------------------------------
module stepper_step_dir_pulse_generator_top_test;
    import sdp_pkg::*;

    localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES = 6;
    localparam int WORDS_PER_PHASE = 95;

    typedef enum logic [1:0] {
        CMD_WORD  = 2'd0,
        CMD_REG   = 2'd1,
        CMD_DRAIN = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [FUNC_BITS-1:0]  func;
        logic [CNT_BITS-1:0]   count;
        logic                  cw;
        logic [REQ_BITS-1:0]   req;
        logic [CIDX_BITS-1:0]  reg_idx;
        logic [DLY_BITS-1:0]   reg_val;
    } t_cmd;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_s_tvalid = 1'b0;
    logic                       o_s_tready;
    logic [8*IN_BYTES-1:0]      i_s_tdata = '0;
    logic [FUNC_BITS-1:0]       i_s_tuser = '0;
    logic                       o_m_tvalid;
    logic                       i_m_tready = 1'b0;
    logic [8*OUT_BYTES-1:0]     o_m_tdata;
    logic [EV_BITS-1:0]         o_m_tuser;
    logic                       o_m_tlast;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CIDX_BITS-1:0]       i_cfg_index = '0;
    logic [DLY_BITS-1:0]        i_cfg_data = '0;

    stepper_step_dir_pulse_generator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Axis model state and register copy.
    t_cfg                cfg_model = {RST_DIR_SETUP, RST_MIN_HALF, RST_MAX_HALF};
    t_phase              ax_phase = PH_SETUP;
    logic                ax_busy = 1'b0;
    logic [CNT_BITS-1:0] ax_steps = '0;
    logic                ax_dir_cw = 1'b1;
    logic [DLY_BITS-1:0] ax_half = RST_HALF;
    logic [DLY_BITS-1:0] ax_elapsed = '0;
    logic                ax_first = 1'b1;
    logic [31:0]         ax_pos = '0;
    logic                ax_step = 1'b0;
    logic                ax_dir = 1'b0;

    t_cmd    cmd_q[$];
    t_result report_q[$];
    t_cmd    live_word;
    t_cmd    live_reg;
    t_result seen_word;
    t_result want_word;

    logic quiet = 1'b0;
    logic stim_done = 1'b0;
    logic s_hold;
    logic c_hold;
    int   idle_gap = 0;
    int   out_gap = 0;
    int   settle_cnt = 0;
    int   errors = 0;
    int   words_planned = 0;
    int   words_sent = 0;
    int   ignored_sent = 0;
    int   regs_written = 0;
    int   results_checked = 0;
    int   moves_done = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Alternates stretches with random idling and stretches without any.
    always begin
        quiet <= 1'b0;
        repeat ($urandom_range(150, 600)) @(posedge i_clk);
        quiet <= 1'b1;
        repeat ($urandom_range(40, 200)) @(posedge i_clk);
    end

    function automatic int idle_draw();
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic void push_report(input logic [EV_BITS-1:0] ev, input logic was,
                                        input logic [DLY_BITS-1:0] dly, input logic lst);
        t_result r;
        r.event_res     = ev;
        r.step_level    = ax_step;
        r.dir_level     = ax_dir;
        r.position      = ax_pos;
        r.moving        = ax_busy;
        r.was_moving    = was;
        r.applied_delay = dly;
        r.last          = lst;
        report_q.push_back(r);
    endfunction

    task automatic step_axis(output logic [EV_BITS-1:0] ev);
        ev = EV_PIN;
        if (!ax_busy) return;
        if (ax_phase != PH_SETUP && ax_elapsed < 10'd1023)
            ax_elapsed = ax_elapsed + DLY_BITS'(1);
        case (ax_phase)
            PH_HIGH: begin
                if (ax_elapsed >= (ax_first ? cfg_model.dir_setup : ax_half)) begin
                    ax_step    = 1'b1;
                    ax_elapsed = '0;
                    ax_phase   = PH_LOW;
                end
            end
            PH_LOW: begin
                if (ax_elapsed >= ax_half) begin
                    ax_step    = 1'b0;
                    ax_pos     = ax_dir_cw ? ax_pos + 1 : ax_pos - 1;
                    ax_steps   = ax_steps - CNT_BITS'(1);
                    ax_elapsed = '0;
                    if (ax_steps == '0) begin
                        ax_busy = 1'b0;
                        ev      = EV_DONE;
                    end else begin
                        ax_first = 1'b0;
                        ax_phase = PH_HIGH;
                    end
                end
            end
            default: begin
                ax_dir     = ax_dir_cw;
                ax_elapsed = '0;
                ax_phase   = PH_HIGH;
            end
        endcase
    endtask

    task automatic axis_apply(input t_cmd c);
        logic [EV_BITS-1:0]  ev;
        logic [DLY_BITS-1:0] d;
        logic                was;
        case (c.func)
            FUNC_TICK: begin
                step_axis(ev);
                push_report(ev, 1'b0, '0, 1'b1);
            end
            FUNC_START: begin
                if (c.count == '0) begin
                    push_report(EV_BAD, 1'b0, '0, 1'b1);
                end else begin
                    if (ax_busy) push_report(EV_CANCEL, 1'b0, '0, 1'b0);
                    if (c.req < cfg_model.min_half) d = cfg_model.min_half;
                    else if (c.req > cfg_model.max_half) d = cfg_model.max_half;
                    else d = c.req[DLY_BITS-1:0];
                    ax_steps   = c.count;
                    ax_dir_cw  = c.cw;
                    ax_half    = d;
                    ax_phase   = PH_SETUP;
                    ax_first   = 1'b1;
                    ax_elapsed = '0;
                    ax_busy    = 1'b1;
                    push_report(EV_ACK, 1'b0, d, 1'b1);
                end
            end
            FUNC_STOP: begin
                was     = ax_busy;
                ax_busy = 1'b0;
                push_report(EV_STOP, was, '0, 1'b1);
            end
            default: ;
        endcase
    endtask

    // Driver: presents queued words and register writes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            idle_gap    = 0;
            settle_cnt  = 0;
        end else begin
            s_hold = i_s_tvalid;
            c_hold = i_cfg_valid;
            if (i_s_tvalid && o_s_tready) begin
                axis_apply(live_word);
                if (live_word.func == FUNC_UNUSED) ignored_sent++;
                words_sent++;
                s_hold = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DIR_SETUP: cfg_model.dir_setup = i_cfg_data;
                    CFG_MIN_HALF:  cfg_model.min_half = i_cfg_data;
                    CFG_MAX_HALF:  cfg_model.max_half = i_cfg_data;
                    default: ;
                endcase
                regs_written++;
                c_hold = 1'b0;
            end
            if (!s_hold && !c_hold && cmd_q.size() > 0) begin
                if (idle_gap > 0) begin
                    idle_gap--;
                end else if (cmd_q[0].kind == CMD_WORD) begin
                    live_word = cmd_q.pop_front();
                    i_s_tdata <= {{(8*IN_BYTES-REQ_BITS-1-CNT_BITS){1'b0}},
                                  live_word.req, live_word.cw, live_word.count};
                    i_s_tuser <= live_word.func;
                    s_hold    = 1'b1;
                    idle_gap  = idle_draw();
                end else if (report_q.size() != 0) begin
                    settle_cnt = 0;
                end else if (settle_cnt < SETTLE_CYCLES) begin
                    settle_cnt++;
                end else begin
                    settle_cnt = 0;
                    live_reg = cmd_q.pop_front();
                    if (live_reg.kind == CMD_REG) begin
                        i_cfg_index <= live_reg.reg_idx;
                        i_cfg_data  <= live_reg.reg_val;
                        c_hold      = 1'b1;
                    end
                end
            end
            i_s_tvalid  <= s_hold;
            i_cfg_valid <= c_hold;
            stim_done   <= (cmd_q.size() == 0) && !s_hold && !c_hold;
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Monitor: accepts result words with random stalls and checks them in order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            out_gap    = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                seen_word.event_res     = o_m_tuser;
                seen_word.step_level    = o_m_tdata[0];
                seen_word.dir_level     = o_m_tdata[1];
                seen_word.position      = o_m_tdata[33:2];
                seen_word.moving        = o_m_tdata[34];
                seen_word.was_moving    = o_m_tdata[35];
                seen_word.applied_delay = o_m_tdata[45:36];
                seen_word.last          = o_m_tlast;
                if (report_q.size() == 0) begin
                    $error("Result word arrived with no expected word pending.");
                    errors++;
                end else begin
                    want_word = report_q.pop_front();
                    check_field("event_res", int'(want_word.event_res),
                                int'(seen_word.event_res));
                    check_field("step_level", int'(want_word.step_level),
                                int'(seen_word.step_level));
                    check_field("dir_level", int'(want_word.dir_level),
                                int'(seen_word.dir_level));
                    check_field("position", int'(want_word.position),
                                int'(seen_word.position));
                    check_field("moving", int'(want_word.moving), int'(seen_word.moving));
                    check_field("was_moving", int'(want_word.was_moving),
                                int'(seen_word.was_moving));
                    check_field("applied_delay", int'(want_word.applied_delay),
                                int'(seen_word.applied_delay));
                    check_field("last", int'(want_word.last), int'(seen_word.last));
                    if (want_word.event_res == EV_DONE) moves_done++;
                    results_checked++;
                end
                out_gap = idle_draw();
            end
            if (out_gap > 0) begin
                out_gap--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic add_word(input logic [FUNC_BITS-1:0] f, input int cnt, input int cw,
                            input int req);
        t_cmd c;
        c       = '0;
        c.kind  = CMD_WORD;
        c.func  = f;
        c.count = cnt[CNT_BITS-1:0];
        c.cw    = cw[0];
        c.req   = req[REQ_BITS-1:0];
        cmd_q.push_back(c);
        if (f != FUNC_UNUSED) words_planned++;
    endtask

    task automatic add_reg(input logic [CIDX_BITS-1:0] idx, input int val);
        t_cmd c;
        c         = '0;
        c.kind    = CMD_REG;
        c.reg_idx = idx;
        c.reg_val = val[DLY_BITS-1:0];
        cmd_q.push_back(c);
    endtask

    task automatic add_drain();
        t_cmd c;
        c      = '0;
        c.kind = CMD_DRAIN;
        cmd_q.push_back(c);
    endtask

    task automatic add_ticks(input int n);
        repeat (n) add_word(FUNC_TICK, $urandom_range(0, 20'hFFFFF), $urandom_range(0, 1),
                            $urandom_range(0, 16'hFFFF));
    endtask

    // A start followed by roughly enough ticks to finish it, with the odd stop,
    // restart, rejected or unused word mixed in.
    task automatic random_move(input int dsetup, input int hmax);
        int cnt;
        int req;
        int need;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) cnt = $urandom_range(1, 4);
        else if (pick < 88) cnt = 0;
        else cnt = $urandom_range(1, 20'hFFFFF);
        pick = $urandom_range(0, 99);
        if (pick < 60) req = $urandom_range(0, 12);
        else if (pick < 80) req = $urandom_range(0, 1100);
        else req = $urandom_range(0, 16'hFFFF);
        add_word(FUNC_START, cnt, $urandom_range(0, 1), req);
        need = dsetup + 2 * hmax * ((cnt > 4) ? 4 : cnt) + 3;
        if (need > 45) need = 45;
        repeat ($urandom_range(1, need + 3)) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                add_word(FUNC_STOP, $urandom_range(0, 20'hFFFFF), $urandom_range(0, 1),
                         $urandom_range(0, 16'hFFFF));
            else if (pick < 5)
                add_word(FUNC_START, $urandom_range(1, 3), $urandom_range(0, 1),
                         $urandom_range(0, 12));
            else if (pick < 6)
                add_word(FUNC_UNUSED, $urandom_range(0, 20'hFFFFF), $urandom_range(0, 1),
                         $urandom_range(0, 16'hFFFF));
            else if (pick < 7)
                add_word(FUNC_START, 0, $urandom_range(0, 1), $urandom_range(0, 16'hFFFF));
            else
                add_ticks(1);
        end
    endtask

    initial begin : stimulus
        int ph_dir[PHASES];
        int ph_min[PHASES];
        int ph_max[PHASES];
        int target;
        int p;
        ph_dir = '{1, 3, 1, 2, 1000, 5};
        ph_min = '{1, 2, 4, 1, 1000, 1};
        ph_max = '{3, 2, 1, 6, 1000, 1};

        // Reset settings: idle words, rejected count, clamping at both ends, cancels.
        add_word(FUNC_TICK, 0, 0, 0);
        add_word(FUNC_STOP, 0, 0, 0);
        add_word(FUNC_START, 0, 1, 500);
        add_word(FUNC_UNUSED, 20'hFFFFF, 1, 16'hFFFF);
        add_word(FUNC_START, 20'hFFFFF, 0, 0);
        add_word(FUNC_START, 3, 1, 16'hFFFF);
        add_word(FUNC_START, 1, 0, 350);
        add_ticks(3);
        add_word(FUNC_STOP, 0, 0, 0);
        add_ticks(1);

        // Short delays: one full counter-clockwise step to completion.
        add_reg(CFG_DIR_SETUP, 1);
        add_reg(CFG_MIN_HALF, 2);
        add_reg(CFG_MAX_HALF, 5);
        add_word(FUNC_START, 1, 0, 9);
        add_ticks(8);

        for (p = 0; p < PHASES; p++) begin
            add_reg(CFG_DIR_SETUP, ph_dir[p]);
            add_reg(CFG_MIN_HALF, ph_min[p]);
            add_reg(CFG_MAX_HALF, ph_max[p]);
            target = words_planned + WORDS_PER_PHASE;
            while (words_planned < target) begin
                if ($urandom_range(0, 9) == 0)
                    add_word(FUNC_BITS'($urandom_range(0, 3)), $urandom_range(0, 20'hFFFFF),
                             $urandom_range(0, 1), $urandom_range(0, 16'hFFFF));
                else
                    random_move(ph_dir[p], (ph_min[p] > ph_max[p]) ? ph_min[p] : ph_max[p]);
                if ($urandom_range(0, 14) == 0) add_drain();
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (stim_done);
        wait (report_q.size() == 0);
        repeat (12) @(posedge i_clk);
        $display("Sent %0d command words (%0d with an unused code) and %0d register writes.",
                 words_sent, ignored_sent, regs_written);
        $display("Checked %0d result words; %0d moves ran to completion.",
                 results_checked, moves_done);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
